// File: hw/rtl/qft_pkg.sv
// ----------------------------------------------------------------------------
// qft_pkg
// Shared types and constants of the quoted field tokenizer.
// ----------------------------------------------------------------------------
package qft_pkg;

  localparam int LineBitsDefault = 20;
  localparam int LineOutW        = 20;

  localparam logic [7:0] CharQuote   = 8'h22;
  localparam logic [7:0] CharNewline = 8'h0a;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharCr      = 8'h0d;
  localparam logic [7:0] CharTab     = 8'h09;
  localparam logic [7:0] CharNul     = 8'h00;

  typedef enum logic [1:0] {
    KindByte  = 2'd0,
    KindField = 2'd1,
    KindLine  = 2'd2,
    KindError = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ModeNormal = 2'd0,
    ModeString = 2'd1,
    ModeQuote  = 2'd2,
    ModeFailed = 2'd3
  } mode_e;

  typedef struct packed {
    kind_e                kind;
    logic [7:0]           data;
    logic [LineOutW-1:0]  line;
    logic                 last;
  } result_t;

endpackage

// File: hw/rtl/qft_lexer.sv
// ----------------------------------------------------------------------------
// qft_lexer
// Lexer state and per-byte decode: up to two results for each request.
// ----------------------------------------------------------------------------
module qft_lexer import qft_pkg::*; #(
  parameter int LineBits = LineBitsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [7:0]    byte_i,
  input  logic          end_i,
  output logic [1:0]    num_o,
  output result_t [1:0] res_o
);

  localparam int ExtW = LineBits + LineOutW;

  mode_e                mode_q, mode_d;
  logic                 field_open_q, field_open_d;
  logic                 has_fields_q, has_fields_d;
  logic                 halted_q, halted_d;
  logic [LineBits-1:0]  lines_q, lines_d;
  logic [LineBits-1:0]  lines_inc;
  logic [ExtW-1:0]      ext_cur, ext_inc;
  logic [LineOutW-1:0]  line_cur, line_inc;
  logic                 is_sep;

  assign lines_inc = (lines_q == '1) ? lines_q : lines_q + LineBits'(1);
  assign ext_cur   = {{LineOutW{1'b0}}, lines_q};
  assign ext_inc   = {{LineOutW{1'b0}}, lines_inc};
  assign line_cur  = ext_cur[LineOutW-1:0];
  assign line_inc  = ext_inc[LineOutW-1:0];
  assign is_sep    = (byte_i == CharSpace) || (byte_i == CharCr) ||
                     (byte_i == CharTab) || (byte_i == CharNul);

  always_comb begin
    mode_d       = mode_q;
    field_open_d = field_open_q;
    has_fields_d = has_fields_q;
    halted_d     = halted_q;
    lines_d      = lines_q;
    num_o        = 2'd0;
    res_o[0]     = '{kind: KindByte, data: 8'h00, line: line_cur, last: 1'b1};
    res_o[1]     = '{kind: KindLine, data: 8'h00, line: line_cur, last: 1'b1};
    if (halted_q) begin
      if (mode_q == ModeFailed) begin
        num_o         = 2'd1;
        res_o[0].kind = KindError;
        res_o[0].line = line_inc;
      end
    end else if (end_i) begin
      mode_d       = ModeNormal;
      halted_d     = 1'b1;
      field_open_d = 1'b0;
      has_fields_d = 1'b0;
      if (field_open_q) begin
        num_o         = 2'd2;
        res_o[0].kind = KindField;
        res_o[0].last = 1'b0;
      end else if (has_fields_q) begin
        num_o         = 2'd1;
        res_o[0].kind = KindLine;
      end
    end else if (mode_q == ModeString) begin
      if (byte_i == CharNewline) begin
        mode_d        = ModeFailed;
        halted_d      = 1'b1;
        num_o         = 2'd1;
        res_o[0].kind = KindError;
        res_o[0].line = line_inc;
      end else if (byte_i == CharQuote) begin
        mode_d = ModeQuote;
      end else begin
        field_open_d  = 1'b1;
        num_o         = 2'd1;
        res_o[0].data = byte_i;
      end
    end else if (mode_q == ModeQuote && byte_i == CharQuote) begin
      mode_d        = ModeString;
      field_open_d  = 1'b1;
      num_o         = 2'd1;
      res_o[0].data = byte_i;
    end else begin
      mode_d = ModeNormal;
      if (byte_i == CharQuote) begin
        mode_d = ModeString;
      end else if (byte_i == CharNewline) begin
        lines_d      = lines_inc;
        field_open_d = 1'b0;
        has_fields_d = 1'b0;
        res_o[1].line = line_inc;
        if (field_open_q) begin
          num_o         = 2'd2;
          res_o[0].kind = KindField;
          res_o[0].last = 1'b0;
        end else begin
          num_o         = 2'd1;
          res_o[0].kind = KindLine;
          res_o[0].line = line_inc;
        end
      end else if (is_sep) begin
        if (field_open_q) begin
          num_o         = 2'd1;
          res_o[0].kind = KindField;
          field_open_d  = 1'b0;
          has_fields_d  = 1'b1;
        end
      end else begin
        field_open_d  = 1'b1;
        num_o         = 2'd1;
        res_o[0].data = byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeNormal;
      field_open_q <= 1'b0;
      has_fields_q <= 1'b0;
      halted_q     <= 1'b0;
      lines_q      <= '0;
    end else if (en_i) begin
      mode_q       <= mode_d;
      field_open_q <= field_open_d;
      has_fields_q <= has_fields_d;
      halted_q     <= halted_d;
      lines_q      <= lines_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (halted_q && mode_q != ModeFailed) |-> (num_o == 2'd0))
    else $error("results after stream end");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeFailed) |-> halted_q)
    else $error("failed mode without halt");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && !halted_q && !end_i && byte_i != CharNewline) |=> $stable(lines_q))
    else $error("line count moved without newline");

endmodule

// File: hw/rtl/quoted_field_tokenizer.sv
// ----------------------------------------------------------------------------
// quoted_field_tokenizer
// Splits a byte stream into fields and lines, honouring quoted strings.
// ----------------------------------------------------------------------------
// Output: registered; results appear in the cycle after the request is taken.
// Flow: one request per cycle while each gives at most one result and the
// output is not stalled; a request giving two results stalls the input until
// the first is out (two-entry buffer: one result per cycle unless stalled).
// Reset: asynchronous, active low; lexer normal, line count zero, buffer empty.
module quoted_field_tokenizer import qft_pkg::*; #(
  parameter int LineBits = LineBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        stream_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic [19:0] line_number_o,
  output logic        run_last_o
);

  logic          push, pop;
  logic [1:0]    res_num;
  result_t [1:0] res;
  result_t [1:0] buf_q, buf_d;
  logic [1:0]    count_q, count_d;

  assign in_stall_o = (count_q == 2'd2) || ((count_q == 2'd1) && out_stall_i);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;

  qft_lexer #(
    .LineBits(LineBits)
  ) u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (push),
    .byte_i (in_byte_i),
    .end_i  (stream_end_i),
    .num_o  (res_num),
    .res_o  (res)
  );

  always_comb begin
    buf_d   = buf_q;
    count_d = count_q - {1'b0, pop};
    if (pop && count_q == 2'd2) begin
      buf_d[0] = buf_q[1];
    end
    if (push) begin
      buf_d   = res;
      count_d = res_num;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  assign out_valid_o   = (count_q != 2'd0);
  assign kind_o        = buf_q[0].kind;
  assign out_byte_o    = buf_q[0].data;
  assign line_number_o = buf_q[0].line;
  assign run_last_o    = buf_q[0].last;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result buffer overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && res_num == 2'd2) |=> (count_q == 2'd2 && !run_last_o))
    else $error("pair of results lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2) |-> !buf_q[0].last)
    else $error("first of a pair marked last");

endmodule
